FILE: sv/tlc_pkg.sv
// Types, op codes and reset constants for the traverse layer controller.
// No dependencies; used by the interfaces, tlc_step and the top level.
package tlc_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_TICK       = 3'd0;
  localparam op_t OP_RUN        = 3'd1;
  localparam op_t OP_STOP       = 3'd2;
  localparam op_t OP_FORWARD    = 3'd3;
  localparam op_t OP_BACKWARD   = 3'd4;
  localparam op_t OP_TOGGLE     = 3'd5;
  localparam op_t OP_SEEK_BEGIN = 3'd6;
  localparam op_t OP_SEEK_END   = 3'd7;

  localparam int unsigned STEP_W  = 17;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned MAX_W   = 16;
  localparam int unsigned EVENT_W = 2;

  localparam logic [MAX_W-1:0] MAX_STEP_RESET = 16'd100;
  localparam logic [STEP_W-1:0] STEP_LIMIT    = 17'h10000;

  typedef struct packed {
    op_t  op;
    logic encoder_level;
    logic at_begin;
    logic at_end;
    logic stop_lamp;
  } item_t;

  typedef struct packed {
    logic               drive_enabled;
    logic               direction_back;
    logic               stepping;
    logic [STEP_W-1:0]  step_count;
    logic               prev_encoder;
    logic [TOTAL_W-1:0] edge_total;
  } state_t;

  typedef struct packed {
    logic               drive_on;
    logic               moving_backward;
    logic               step_mode;
    logic [STEP_W-1:0]  step_pulses;
    logic [TOTAL_W-1:0] total_pulses;
    logic [EVENT_W-1:0] control_events;
  } result_t;

  localparam state_t STATE_RESET = '{
    drive_enabled:  1'b0,
    direction_back: 1'b0,
    stepping:       1'b1,
    step_count:     '0,
    prev_encoder:   1'b0,
    edge_total:     '0
  };

endpackage

FILE: sv/tlc_if.sv
// Handshake channels of the traverse layer controller: items, results, config.
// Depends on tlc_pkg.
interface tlc_item_if;
  import tlc_pkg::*;
  logic valid;
  logic ready;
  op_t  op;
  logic encoder_level;
  logic at_begin;
  logic at_end;
  logic stop_lamp;

  modport source (output valid, op, encoder_level, at_begin, at_end, stop_lamp,
                  input ready);
  modport sink (input valid, op, encoder_level, at_begin, at_end, stop_lamp,
                output ready);
endinterface

interface tlc_result_if;
  import tlc_pkg::*;
  logic               valid;
  logic               ready;
  logic               drive_on;
  logic               moving_backward;
  logic               step_mode;
  logic [STEP_W-1:0]  step_pulses;
  logic [TOTAL_W-1:0] total_pulses;
  logic [EVENT_W-1:0] control_events;

  modport source (output valid, drive_on, moving_backward, step_mode, step_pulses,
                  total_pulses, control_events, input ready);
  modport sink (input valid, drive_on, moving_backward, step_mode, step_pulses,
                total_pulses, control_events, output ready);
endinterface

interface tlc_cfg_if;
  import tlc_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/tlc_step.sv
// Next-state and result logic for one item of the traverse controller.
// Purely combinational; depends on tlc_pkg.
module tlc_step (
  input  tlc_pkg::item_t                item,
  input  tlc_pkg::state_t               state,
  input  logic [tlc_pkg::MAX_W-1:0]     max_step_pulses,
  output tlc_pkg::state_t               state_next,
  output tlc_pkg::result_t              result
);
  import tlc_pkg::*;

  state_t             nx;
  logic [EVENT_W-1:0] events;
  logic               fall;

  always_comb begin
    nx     = state;
    events = '0;
    fall   = 1'b0;
    unique case (item.op)
      OP_RUN: begin
        if (!item.stop_lamp) begin
          nx.step_count    = '0;
          nx.drive_enabled = 1'b1;
        end
      end
      OP_STOP: begin
        nx.drive_enabled = 1'b0;
        nx.step_count    = '0;
      end
      OP_FORWARD:  nx.direction_back = 1'b0;
      OP_BACKWARD: nx.direction_back = 1'b1;
      OP_TOGGLE:   nx.direction_back = !state.direction_back;
      OP_SEEK_BEGIN: begin
        if (!item.stop_lamp && !item.at_begin) begin
          nx.stepping       = 1'b0;
          nx.direction_back = 1'b1;
          nx.step_count     = '0;
          nx.drive_enabled  = 1'b1;
        end
      end
      OP_SEEK_END: begin
        if (!item.stop_lamp && !item.at_end) begin
          nx.stepping       = 1'b0;
          nx.direction_back = 1'b0;
          nx.step_count     = '0;
          nx.drive_enabled  = 1'b1;
        end
      end
      OP_TICK: begin
        fall = !item.encoder_level && state.prev_encoder;
        if (fall) nx.edge_total = state.edge_total + TOTAL_W'(1);
        if (state.drive_enabled) begin
          if (item.at_begin && nx.direction_back) begin
            nx.drive_enabled  = 1'b0;
            nx.step_count     = '0;
            nx.direction_back = 1'b0;
            nx.stepping       = 1'b1;
            events            = events + EVENT_W'(1);
          end
          // direction here is the one left by the begin check
          if (item.at_end && !nx.direction_back) begin
            nx.drive_enabled  = 1'b0;
            nx.step_count     = '0;
            nx.direction_back = 1'b1;
            nx.stepping       = 1'b1;
            events            = events + EVENT_W'(1);
          end
          // pulse limit is checked even right after a limit-switch stop
          if (fall && nx.stepping) begin
            nx.step_count = nx.step_count + STEP_W'(1);
            if (nx.step_count > {1'b0, max_step_pulses}) begin
              nx.drive_enabled = 1'b0;
              nx.step_count    = '0;
              events           = events + EVENT_W'(1);
            end
          end
        end
        nx.prev_encoder = item.encoder_level;
      end
      default: nx = state;
    endcase
  end

  assign state_next             = nx;
  assign result.drive_on        = nx.drive_enabled;
  assign result.moving_backward = nx.direction_back;
  assign result.step_mode       = nx.stepping;
  assign result.step_pulses     = nx.step_count;
  assign result.total_pulses    = nx.edge_total;
  assign result.control_events  = events;

endmodule

FILE: sv/traverse_layer_controller.sv
// Channel    | Dir | Payload
// items      | in  | op, encoder_level, at_begin, at_end, stop_lamp
// results    | out | drive_on, moving_backward, step_mode, step_pulses,
//            |     | total_pulses, control_events
// cfg        | in  | data = max_step_pulses
//
// One item per cycle while results are taken: an item is registered in the input
// register, and the step logic updates the controller state as it moves into the
// result register, where results.valid flags it until it is taken.
// Synchronous reset clears state, sets stepping; max_step_pulses returns to 100.
// A stalled result holds the result register; the input register still takes
// an item, then items waits until the result moves on. cfg is always ready.
// Depends on tlc_pkg, tlc_if and tlc_step.
module traverse_layer_controller (
  input  logic          clk,
  input  logic          rst,
  tlc_item_if.sink      items,
  tlc_result_if.source  results,
  tlc_cfg_if.sink       cfg
);
  import tlc_pkg::*;

  item_t            in_item;
  logic             in_valid;
  result_t          res;
  logic             res_valid;
  state_t           state;
  state_t           state_next;
  result_t          step_result;
  logic [MAX_W-1:0] max_step_pulses;
  logic             advance;

  assign advance     = in_valid && (!res_valid || results.ready);
  assign items.ready = !in_valid || advance;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
    if (items.ready && items.valid) begin
      in_item.op            <= items.op;
      in_item.encoder_level <= items.encoder_level;
      in_item.at_begin      <= items.at_begin;
      in_item.at_end        <= items.at_end;
      in_item.stop_lamp     <= items.stop_lamp;
    end
  end

  tlc_step u_step (
    .item            (in_item),
    .state           (state),
    .max_step_pulses (max_step_pulses),
    .state_next      (state_next),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= STATE_RESET;
      max_step_pulses <= MAX_STEP_RESET;
    end else begin
      if (advance) state <= state_next;
      if (cfg.valid) max_step_pulses <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (advance) res <= step_result;
  end

  assign results.valid           = res_valid;
  assign results.drive_on        = res.drive_on;
  assign results.moving_backward = res.moving_backward;
  assign results.step_mode       = res.step_mode;
  assign results.step_pulses     = res.step_pulses;
  assign results.total_pulses    = res.total_pulses;
  assign results.control_events  = res.control_events;

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!state.drive_enabled && state.stepping && state.step_count == '0))
    else $error("state not cleared by reset");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state.step_count <= STEP_LIMIT)
    else $error("step count above bound");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> results.valid)
    else $error("item lost between input and result register");

endmodule
